FILE: rtl/rthsv_pkg.sv
// rthsv_pkg: constants and stage types for the rgb to hsv converter
// no dependencies; used by rthsv_front, rthsv_cell and rgb_to_hsv_converter

package rthsv_pkg;

    // channel and fixed point widths
    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    // one divider cell per quotient bit, saturation needs one integer bit
    localparam int QUO_BITS  = FRACTION_BITS + 1;
    localparam int NUM_CELLS = QUO_BITS;

    // hue divisor 6*d stays below 2^(CHANNEL_BITS+3), partial remainder below twice that
    localparam int REM_BITS = CHANNEL_BITS + 4;

    // packed stream widths
    localparam int IN_BITS  = 3 * CHANNEL_BITS;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = FRACTION_BITS + QUO_BITS + CHANNEL_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // saturation value that stands for 1.0
    localparam logic [QUO_BITS-1:0] SAT_FULL = QUO_BITS'(1) << FRACTION_BITS;

    // payload carried from cell to cell
    typedef struct packed {
        logic [REM_BITS-1:0]     rem_sat;
        logic [REM_BITS-1:0]     div_sat;
        logic [REM_BITS-1:0]     rem_hue;
        logic [REM_BITS-1:0]     div_hue;
        logic [QUO_BITS-1:0]     quo_sat;
        logic [QUO_BITS-1:0]     quo_hue;
        logic                    grey;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_stage;

endpackage

FILE: rtl/rthsv_front.sv
// rthsv_front: max/min search and sector numerator, first pipeline register
// depends on rthsv_pkg

module rthsv_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [rthsv_pkg::CHANNEL_BITS-1:0] i_red,
    input  logic [rthsv_pkg::CHANNEL_BITS-1:0] i_green,
    input  logic [rthsv_pkg::CHANNEL_BITS-1:0] i_blue,
    output logic                              o_valid,
    output rthsv_pkg::t_stage                 o_data
);

    localparam int CB = rthsv_pkg::CHANNEL_BITS;
    localparam int RB = rthsv_pkg::REM_BITS;

    logic              r_valid;
    rthsv_pkg::t_stage r_data;
    rthsv_pkg::t_stage n_data;

    logic [CB-1:0] mx;
    logic [CB-1:0] mn;
    logic [RB-1:0] d;
    logic [RB-1:0] d6;
    logic [RB-1:0] num;
    logic [RB-1:0] red_w;
    logic [RB-1:0] green_w;
    logic [RB-1:0] blue_w;

    // largest and smallest channel, red wins ties over green, green over blue
    always_comb begin
        red_w   = RB'(i_red);
        green_w = RB'(i_green);
        blue_w  = RB'(i_blue);
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        d  = RB'(mx) - RB'(mn);
        d6 = (d << 2) + (d << 1);
    end

    // sector numerator, lies in [0, 6d)
    always_comb begin
        if (mx == i_red) begin
            if (i_green >= i_blue) num = green_w - blue_w;
            else                   num = d6 - (blue_w - green_w);
        end else if (mx == i_green) begin
            if (i_blue >= i_red) num = (d << 1) + (blue_w - red_w);
            else                 num = (d << 1) - (red_w - blue_w);
        end else begin
            if (i_red >= i_green) num = (d << 2) + (red_w - green_w);
            else                  num = (d << 2) - (green_w - red_w);
        end
    end

    // seed the divider lanes
    always_comb begin
        n_data.rem_sat    = d;
        n_data.div_sat    = RB'(mx);
        n_data.rem_hue    = num;
        n_data.div_hue    = d6;
        n_data.quo_sat    = '0;
        n_data.quo_hue    = '0;
        n_data.grey       = (d == '0);
        n_data.brightness = mx;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/rthsv_cell.sv
// rthsv_cell: one restoring division step for the saturation and hue lanes
// depends on rthsv_pkg

module rthsv_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rthsv_pkg::t_stage i_data,
    output logic              o_valid,
    output rthsv_pkg::t_stage o_data
);

    localparam int RB = rthsv_pkg::REM_BITS;
    localparam int QB = rthsv_pkg::QUO_BITS;

    logic              r_valid;
    rthsv_pkg::t_stage r_data;
    rthsv_pkg::t_stage n_data;

    logic          bit_sat;
    logic          bit_hue;
    logic [RB-1:0] left_sat;
    logic [RB-1:0] left_hue;

    // compare, subtract, shift for both lanes
    always_comb begin
        bit_sat  = (i_data.rem_sat >= i_data.div_sat);
        bit_hue  = (i_data.rem_hue >= i_data.div_hue);
        left_sat = bit_sat ? (i_data.rem_sat - i_data.div_sat) : i_data.rem_sat;
        left_hue = bit_hue ? (i_data.rem_hue - i_data.div_hue) : i_data.rem_hue;
        n_data         = i_data;
        n_data.rem_sat = left_sat << 1;
        n_data.rem_hue = left_hue << 1;
        n_data.quo_sat = {i_data.quo_sat[QB-2:0], bit_sat};
        n_data.quo_hue = {i_data.quo_hue[QB-2:0], bit_hue};
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: streaming rgb to hsv conversion, front stage plus divider cell chain
// depends on rthsv_pkg, rthsv_front, rthsv_cell
// registered stages: one front stage, 17 divider cells
// throughput: one pixel per cycle while the output is not stalled, one quotient bit of both divisions per cell
// the whole chain advances while the last stage is empty or taken downstream
// reset (i_rst_n low, synchronous) empties every stage; no other state is kept

module rgb_to_hsv_converter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [8*rthsv_pkg::IN_BYTES-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // hue [15:0], saturation [32:16], brightness [40:33], zero fill above
    output logic [8*rthsv_pkg::OUT_BYTES-1:0]    o_m_axis_tdata
);

    localparam int CB = rthsv_pkg::CHANNEL_BITS;
    localparam int FB = rthsv_pkg::FRACTION_BITS;
    localparam int QB = rthsv_pkg::QUO_BITS;
    localparam int NC = rthsv_pkg::NUM_CELLS;

    logic              en;
    logic              valid [NC+1];
    rthsv_pkg::t_stage data  [NC+1];
    rthsv_pkg::t_stage last;

    logic [FB-1:0] hue;
    logic [QB-1:0] saturation;
    logic [CB-1:0] brightness;

    // pipeline moves when the output slot is free or being taken
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // max, min and numerator
    rthsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_red   (i_s_axis_tdata[CB-1:0]),
        .i_green (i_s_axis_tdata[2*CB-1:CB]),
        .i_blue  (i_s_axis_tdata[3*CB-1:2*CB]),
        .o_valid (valid[0]),
        .o_data  (data[0])
    );

    // divider chain, msb of the quotient first
    for (genvar k = 0; k < NC; k++) begin : g_cell
        rthsv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (valid[k]),
            .i_data  (data[k]),
            .o_valid (valid[k+1]),
            .o_data  (data[k+1])
        );
    end

    // grey and black give zero hue and saturation
    assign last       = data[NC];
    assign hue        = last.grey ? '0 : last.quo_hue[FB-1:0];
    assign saturation = last.grey ? '0 : last.quo_sat;
    assign brightness = last.brightness;

    assign o_m_axis_tvalid = valid[NC];
    assign o_m_axis_tdata  = (8*rthsv_pkg::OUT_BYTES)'({brightness, saturation, hue});

    // saturation never exceeds full scale
    a_sat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (saturation <= rthsv_pkg::SAT_FULL))
        else $error("saturation above full scale");

    // black pixel gives zero hue and saturation
    a_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && brightness == '0) |-> (saturation == '0 && hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    // zero saturation only for grey, which has zero hue
    a_grey : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && saturation == '0) |-> (hue == '0))
        else $error("zero saturation with nonzero hue");

    // hue quotient never reaches a full turn
    a_hue_msb : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !last.grey) |-> !last.quo_hue[QB-1])
        else $error("hue quotient overflow");

endmodule

FILE: sim/tb.sv
// tb: self-checking stream testbench for rgb_to_hsv_converter
// depends on rthsv_pkg and the converter rtl
// predicts hsv per pixel and checks each result in order

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB        = rthsv_pkg::CHANNEL_BITS;
    localparam int FB        = rthsv_pkg::FRACTION_BITS;
    localparam int QB        = rthsv_pkg::QUO_BITS;
    localparam int IN_BYTES  = rthsv_pkg::IN_BYTES;
    localparam int OUT_BYTES = rthsv_pkg::OUT_BYTES;

    typedef logic [CB-1:0] t_chan;

    typedef struct packed {
        logic [FB-1:0] hue;
        logic [QB-1:0] saturation;
        t_chan         brightness;
    } t_hsv;

    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES  = 40;
    localparam int TIMEOUT_NS   = 3_200_000;

    logic                      i_clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_valid = 1'b0;
    logic [8*IN_BYTES-1:0]     s_data = '0;
    logic                      m_ready = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic [8*OUT_BYTES-1:0]    m_data;

    // expected results in arrival order
    t_hsv hsv_queue[$];

    int  error_count    = 0;
    int  pixels_sent    = 0;
    int  results_seen   = 0;
    int  grey_sent      = 0;
    int  hold_cycles    = 0;
    bit  src_idle_on    = 1'b1;
    bit  sink_idle_on   = 1'b1;

    rgb_to_hsv_converter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("rgb_to_hsv_converter: mismatch");
        $finish;
    end

    // hsv of one pixel, six-sector hue with truncating division
    function automatic t_hsv predict_hsv(input t_chan r, input t_chan g, input t_chan b);
        logic [31:0] mx, mn, d, num;
        t_hsv        res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        res = '0;
        res.brightness = t_chan'(mx);
        if (mx != 0 && d != 0) begin
            res.saturation = QB'((d << FB) / mx);
            // sector value times d, always in [0, 6d)
            if (mx == r) begin
                num = (g >= b) ? g - b : 6 * d - (b - g);
            end else if (mx == g) begin
                num = (b >= r) ? 2 * d + (b - r) : 2 * d - (r - b);
            end else begin
                num = (r >= g) ? 4 * d + (r - g) : 4 * d - (g - r);
            end
            res.hue = FB'((num << FB) / (6 * d));
        end
        return res;
    endfunction

    // channel value biased toward the ends of the range
    function automatic t_chan extreme_chan();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return t_chan'($urandom_range(0, 3));
            default: return t_chan'($urandom);
        endcase
    endfunction

    // random pixel: mostly uniform, with greys, ties and dominant channels mixed in
    function automatic logic [3*CB-1:0] random_pixel();
        t_chan r, g, b, hi, lo;
        r = t_chan'($urandom);
        g = t_chan'($urandom);
        b = t_chan'($urandom);
        hi = t_chan'($urandom);
        lo = t_chan'($urandom_range(0, hi));
        case ($urandom_range(0, 9))
            0: begin
                r = extreme_chan();
                g = r;
                b = r;
            end
            1: begin
                // two channels share the maximum
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = hi; b = lo; end
                    1: begin r = lo; g = hi; b = hi; end
                    default: begin r = hi; g = lo; b = hi; end
                endcase
            end
            2: begin
                r = extreme_chan();
                g = extreme_chan();
                b = extreme_chan();
            end
            3: begin
                // one channel on top, the other two equal
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = lo; b = lo; end
                    1: begin r = lo; g = hi; b = lo; end
                    default: begin r = lo; g = lo; b = hi; end
                endcase
            end
            default: ;
        endcase
        return {b, g, r};
    endfunction

    // one pixel request, with an optional idle burst first
    task automatic send_pixel(input t_chan r, input t_chan g, input t_chan b);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= {b, g, r};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        hsv_queue.push_back(predict_hsv(r, g, b));
        pixels_sent++;
        if (r == g && g == b) grey_sent++;
    endtask

    task automatic send_random_pixel();
        logic [3*CB-1:0] px;
        px = random_pixel();
        send_pixel(px[0 +: CB], px[CB +: CB], px[2*CB +: CB]);
    endtask

    // stop requesting and let every expected result come back
    task automatic wait_for_results();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (hsv_queue.size() != 0) @(posedge i_clk);
    endtask

    // receiver: long hold-offs on request, otherwise random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s wrong, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // result checker against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_hsv got, want;
        if (rst_n && m_valid && m_ready) begin
            got.hue        = m_data[0 +: FB];
            got.saturation = m_data[FB +: QB];
            got.brightness = m_data[FB + QB +: CB];
            results_seen++;
            if (hsv_queue.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual h=%0d s=%0d v=%0d",
                         $time, got.hue, got.saturation, got.brightness);
            end else begin
                want = hsv_queue.pop_front();
                check_field("hue", want.hue, got.hue);
                check_field("saturation", want.saturation, got.saturation);
                check_field("brightness", want.brightness, got.brightness);
            end
        end
    end

    // black, white, greys, primaries, ties and each sector branch
    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd10,  8'd200, 8'd5);
        send_pixel(8'd5,   8'd200, 8'd10);
        send_pixel(8'd90,  8'd30,  8'd240);
        send_pixel(8'd30,  8'd90,  8'd240);
        send_pixel(8'd50,  8'd200, 8'd50);
        send_pixel(8'd50,  8'd50,  8'd200);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd170, 8'd85,  8'd170);
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering, so the pipe backs up
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        hold_cycles = 250;
        repeat (80) send_random_pixel();
        wait_for_results();
        src_idle_on = 1'b1;
    endtask

    // random pixels with idling switched on and off in stretches and a full drain halfway
    task automatic test_random_mix();
        for (int i = 0; i < 1500; i++) begin
            if (i % 250 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == 750) wait_for_results();
            send_random_pixel();
        end
    endtask

    // back to back at full rate, no idling on either side
    task automatic test_streaming();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (350) send_random_pixel();
    endtask

    // sequence
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_mix();
        test_streaming();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d pixels (%0d grey or black) and %0d results, long hold-off,",
                 pixels_sent, grey_sent, results_seen);
        $display("random idle bursts on both sides, a full drain and full-rate streaming");
        if (error_count == 0) begin
            $display("rgb_to_hsv_converter: match");
        end else begin
            $display("rgb_to_hsv_converter: mismatch");
        end
        $finish;
    end

endmodule
